>>> rtl/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared types and constants for the vertex transform / perspective divide.
// ----------------------------------------------------------------------------
package vtpd_pkg;

    localparam int NUM_REGS  = 8;
    localparam int REG_WIDTH = 64;
    localparam int IDX_WIDTH = 3;
    localparam int FLD_WIDTH = 32;
    localparam int COEF_WIDTH = 32;

    localparam logic [REG_WIDTH-1:0] RESET_ONE_LO = 64'd65536;
    localparam logic [REG_WIDTH-1:0] RESET_ONE_HI = 64'd281474976710656;

    typedef logic [REG_WIDTH-1:0] cfg_word_t;

    typedef struct packed {
        logic op;
        logic last;
        logic ovf;
    } side_t;

endpackage

>>> rtl/vtpd_mac.sv
// ----------------------------------------------------------------------------
// vtpd_mac
// One matrix row: four multiplies, registered, then sum, floor and saturate.
// ----------------------------------------------------------------------------
module vtpd_mac #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic signed [vtpd_pkg::COEF_WIDTH-1:0] coef [4],
    input  logic signed [COORD_WIDTH-1:0] v [4],
    output logic signed [COORD_WIDTH-1:0] sum,
    output logic                          ovf
);
    localparam int PW = vtpd_pkg::COEF_WIDTH + COORD_WIDTH;
    localparam int SW = PW + 2;

    logic signed [PW-1:0] prod_reg [4];
    logic signed [SW-1:0] acc;
    logic signed [SW-FRAC_BITS-1:0] shf;
    logic signed [SW-FRAC_BITS-1:0] hi_lim;
    logic signed [SW-FRAC_BITS-1:0] lo_lim;
    logic signed [COORD_WIDTH-1:0] sum_reg;
    logic ovf_reg;
    logic signed [COORD_WIDTH-1:0] sum_next;
    logic ovf_next;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            prod_reg[c] <= PW'(coef[c]) * PW'(v[c]);
        end
        sum_reg <= sum_next;
        ovf_reg <= ovf_next;
    end

    always_comb
    begin
        acc = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]) + SW'(prod_reg[3]);
        shf = acc[SW-1:FRAC_BITS];
        hi_lim = (SW-FRAC_BITS)'({1'b0, {(COORD_WIDTH-1){1'b1}}});
        lo_lim = -hi_lim - (SW-FRAC_BITS)'(1);
        ovf_next = 1'b0;
        if (shf > hi_lim)
        begin
            sum_next = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            ovf_next = 1'b1;
        end
        else if (shf < lo_lim)
        begin
            sum_next = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            ovf_next = 1'b1;
        end
        else
        begin
            sum_next = shf[COORD_WIDTH-1:0];
        end
    end

    assign sum = sum_reg;
    assign ovf = ovf_reg;
endmodule

>>> rtl/vtpd_div.sv
// ----------------------------------------------------------------------------
// vtpd_div
// Pipelined restoring divider, one quotient bit per stage, on magnitudes.
// Computes trunc((n << FRAC_BITS) / d) for three numerators sharing d.
// ----------------------------------------------------------------------------
module vtpd_div #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  vtpd_pkg::side_t               in_side,
    input  logic signed [COORD_WIDTH-1:0] in_n [3],
    input  logic signed [COORD_WIDTH-1:0] in_d,
    output logic                          out_valid,
    output vtpd_pkg::side_t               out_side,
    output logic signed [COORD_WIDTH-1:0] out_q [3],
    output logic signed [COORD_WIDTH-1:0] out_w,
    output logic                          out_ovf,
    output logic                          out_zw
);
    localparam int NW = COORD_WIDTH + FRAC_BITS;
    localparam int ST = NW;

    logic                  v_reg    [ST+1];
    vtpd_pkg::side_t       side_reg [ST+1];
    logic [COORD_WIDTH-1:0] d_reg   [ST+1];
    logic signed [COORD_WIDTH-1:0] dr_reg [ST+1];
    logic [NW-1:0]         num_reg  [ST+1][3];
    logic [NW:0]           rem_reg  [ST+1][3];
    logic                  neg_reg  [ST+1][3];
    logic signed [COORD_WIDTH-1:0] raw_reg [ST+1][3];

    logic [NW:0] trial [ST][3];
    logic [NW:0] shr   [ST][3];

    always_comb
    begin
        for (int s = 0; s < ST; s++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                shr[s][k] = {rem_reg[s][k][NW-1:0], num_reg[s][k][NW-1]};
                trial[s][k] = shr[s][k] - (NW+1)'(d_reg[s]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= ST; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 0; s < ST; s++)
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        dr_reg[0] <= in_d;
        d_reg[0] <= in_d[COORD_WIDTH-1] ? COORD_WIDTH'(-in_d) : COORD_WIDTH'(in_d);
        for (int k = 0; k < 3; k++)
        begin
            neg_reg[0][k] <= in_n[k][COORD_WIDTH-1] ^ in_d[COORD_WIDTH-1];
            num_reg[0][k] <= {(in_n[k][COORD_WIDTH-1] ? COORD_WIDTH'(-in_n[k])
                                                      : COORD_WIDTH'(in_n[k])),
                              {FRAC_BITS{1'b0}}};
            rem_reg[0][k] <= '0;
            raw_reg[0][k] <= in_n[k];
        end
        for (int s = 0; s < ST; s++)
        begin
            side_reg[s+1] <= side_reg[s];
            d_reg[s+1] <= d_reg[s];
            dr_reg[s+1] <= dr_reg[s];
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[s+1][k] <= neg_reg[s][k];
                raw_reg[s+1][k] <= raw_reg[s][k];
                if (!trial[s][k][NW])
                begin
                    rem_reg[s+1][k] <= trial[s][k];
                    num_reg[s+1][k] <= {num_reg[s][k][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1][k] <= shr[s][k];
                    num_reg[s+1][k] <= {num_reg[s][k][NW-2:0], 1'b0};
                end
            end
        end
    end

    // final stage: sign, saturate, select
    localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [NW:0] ONE_WIDE = (NW+1)'(1) << FRAC_BITS;
    localparam logic [NW:0] MAX_WIDE = (NW+1)'(MAXV);

    logic [NW-1:0] mag;
    logic          zw;
    logic          qovf;

    always_comb
    begin
        zw = side_reg[ST].op && (dr_reg[ST] == '0);
        qovf = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            mag = num_reg[ST][k];
            if (!side_reg[ST].op)
            begin
                out_q[k] = raw_reg[ST][k];
            end
            else if (zw)
            begin
                out_q[k] = '0;
            end
            else if (!neg_reg[ST][k])
            begin
                if ({1'b0, mag} > MAX_WIDE)
                begin
                    out_q[k] = MAXV;
                    qovf = 1'b1;
                end
                else
                begin
                    out_q[k] = mag[COORD_WIDTH-1:0];
                end
            end
            else
            begin
                if ({1'b0, mag} > MAX_WIDE + (NW+1)'(1))
                begin
                    out_q[k] = MINV;
                    qovf = 1'b1;
                end
                else
                begin
                    out_q[k] = COORD_WIDTH'(-mag[COORD_WIDTH-1:0]);
                end
            end
        end
        if (!side_reg[ST].op)
        begin
            out_w = dr_reg[ST];
        end
        else if (ONE_WIDE > MAX_WIDE)
        begin
            out_w = MAXV;
        end
        else
        begin
            out_w = ONE_WIDE[COORD_WIDTH-1:0];
        end
    end

    assign out_valid = v_reg[ST];
    assign out_side  = side_reg[ST];
    assign out_ovf   = side_reg[ST].ovf | qovf;
    assign out_zw    = zw;
endmodule

>>> rtl/vertex_transform_perspective_divide_top.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_top
// 4x4 matrix transform of a homogeneous vertex with optional divide by w.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   cfg     | cfg_we             | cfg_index, cfg_data
//   in      | start & !busy      | op, x_in, y_in, z_in, w_in, last_in
//   out     | done (one cycle)   | x_out..w_out, overflow, zero_w, last_out
//
// One item per clock. The input register loads at the accepting edge; done
// then rises after the multiply, sum/saturate and divider entry registers,
// one divider stage per quotient bit and an output register. busy is always
// low; rst_n clears valid bits and loads the identity matrix. The receiver
// cannot stall.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide_top #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic signed [31:0] x_in,
    input  logic signed [31:0] y_in,
    input  logic signed [31:0] z_in,
    input  logic signed [31:0] w_in,
    input  logic        last_in,
    output logic        done,
    output logic signed [31:0] x_out,
    output logic signed [31:0] y_out,
    output logic signed [31:0] z_out,
    output logic signed [31:0] w_out,
    output logic        overflow,
    output logic        zero_w,
    output logic        last_out
);
    vtpd_pkg::cfg_word_t regs_reg [vtpd_pkg::NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[0] <= vtpd_pkg::RESET_ONE_LO;
            regs_reg[1] <= '0;
            regs_reg[2] <= vtpd_pkg::RESET_ONE_HI;
            regs_reg[3] <= '0;
            regs_reg[4] <= '0;
            regs_reg[5] <= vtpd_pkg::RESET_ONE_LO;
            regs_reg[6] <= '0;
            regs_reg[7] <= vtpd_pkg::RESET_ONE_HI;
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    assign busy = 1'b0;

    // input stage
    logic v0_reg, v1_reg, v2_reg;
    vtpd_pkg::side_t s0_reg, s1_reg, s2_reg;
    logic signed [COORD_WIDTH-1:0] vin_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= '{op: op, last: last_in, ovf: 1'b0};
        s1_reg <= s0_reg;
        s2_reg <= s1_reg;
        vin_reg[0] <= x_in[COORD_WIDTH-1:0];
        vin_reg[1] <= y_in[COORD_WIDTH-1:0];
        vin_reg[2] <= z_in[COORD_WIDTH-1:0];
        vin_reg[3] <= w_in[COORD_WIDTH-1:0];
    end

    logic signed [COORD_WIDTH-1:0] t [4];
    logic row_ovf [4];

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        logic signed [vtpd_pkg::COEF_WIDTH-1:0] cf [4];
        always_comb
        begin
            cf[0] = regs_reg[2*r][31:0];
            cf[1] = regs_reg[2*r][63:32];
            cf[2] = regs_reg[2*r+1][31:0];
            cf[3] = regs_reg[2*r+1][63:32];
        end
        vtpd_mac #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_mac (
            .clk  (clk),
            .coef (cf),
            .v    (vin_reg),
            .sum  (t[r]),
            .ovf  (row_ovf[r])
        );
    end

    vtpd_pkg::side_t dside;
    logic signed [COORD_WIDTH-1:0] dnum [3];

    always_comb
    begin
        dside = s2_reg;
        dside.ovf = row_ovf[0] | row_ovf[1] | row_ovf[2] | row_ovf[3];
        dnum[0] = t[0];
        dnum[1] = t[1];
        dnum[2] = t[2];
    end

    logic dv;
    vtpd_pkg::side_t dso;
    logic signed [COORD_WIDTH-1:0] q [3];
    logic signed [COORD_WIDTH-1:0] wq;
    logic dovf, dzw;

    vtpd_div #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_side   (dside),
        .in_n      (dnum),
        .in_d      (t[3]),
        .out_valid (dv),
        .out_side  (dso),
        .out_q     (q),
        .out_w     (wq),
        .out_ovf   (dovf),
        .out_zw    (dzw)
    );

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        x_out    <= 32'(q[0]);
        y_out    <= 32'(q[1]);
        z_out    <= 32'(q[2]);
        w_out    <= 32'(wq);
        overflow <= dovf;
        zero_w   <= dzw;
        last_out <= dso.last;
    end

    assign done = done_reg;
endmodule

>>> rtl/vtpd_checker.sv
// ----------------------------------------------------------------------------
// vtpd_checker
// Port-level checks on the vertex transform block.
// ----------------------------------------------------------------------------
module vtpd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        done,
    input logic        zero_w,
    input logic [31:0] x_out,
    input logic [31:0] w_out
);
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_zw_x: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_w |-> x_out == 32'd0)
        else $error("zero_w with nonzero x");
    a_zw_w: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_w |-> w_out != 32'd0)
        else $error("zero_w with zero w");
endmodule

bind vertex_transform_perspective_divide_top vtpd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .busy(busy), .done(done),
    .zero_w(zero_w), .x_out(x_out), .w_out(w_out)
);
